@@ hw/rtl/bounded_deque_with_remove_macros.svh @@
// Assertion macros used by the deque top level.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Package with the shared types and constants of the bounded deque.
`default_nettype none

package bdq_pkg;

   // Fixed payload widths of the channels.
   localparam int OP_W         = 2;
   localparam int ITEM_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int ITEM_COUNT_W = 5;

   // Default storage shape.
   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH       = 2'd0,
      OP_POP_NEWEST = 2'd1,
      OP_POP_OLDEST = 2'd2,
      OP_REMOVE     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Decoded command broadcast to every cell of the row.
   typedef struct packed {
      logic do_push;        // push accepted and the store is not full
      logic do_pop_oldest;  // pop-oldest accepted and the store is not empty
      logic do_remove;      // remove accepted
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/bdq_req_if.sv @@
// Request channel: operation code and word, with a valid/ready handshake.
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ITEM_W-1:0] item_value;

   modport source (output valid, operation, item_value, input ready);
   modport sink (input valid, operation, item_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bdq_rsp_if.sv @@
// Response channel: popped word, found flag, status and item count.
`default_nettype none

interface bdq_rsp_if import bdq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ITEM_W-1:0]       popped_value;
   logic                    found;
   logic [STATUS_W-1:0]     status;
   logic [ITEM_COUNT_W-1:0] item_count;

   modport source (output valid, popped_value, found, status, item_count, input ready);
   modport sink (input valid, popped_value, found, status, item_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bounded_deque_with_remove.sv @@
// Top level of the bounded deque with remove-by-value, built as a row of cells.
//
// Usage: each request item on req_chan carries an operation (push, pop newest,
// pop oldest, remove value) and a word. Every accepted request yields exactly
// one response item on rsp_chan with the popped word, the found flag, a status
// (ok, empty, full) and the number of stored items after the operation.
// A request is handled at once: all cells compare against the word and shift
// in parallel, so one item per cycle is sustained while each response is taken,
// and the response appears in the cycle after acceptance. The count register
// and the neighbor-to-neighbor match chain through the cell row set this step.
// The response sits in an output register; a new request is accepted in the
// same cycle the waiting response is taken, and when the receiver stalls the
// response holds and no further request is taken.
// Synchronous reset empties the store and drops any pending response; cell
// contents are left as they are, since only entries below the count are read.
`default_nettype none

`include "bounded_deque_with_remove_macros.svh"

module bounded_deque_with_remove import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input wire        clock,
   input wire        reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);

   // Stored item count; cell i is occupied when i is below it.
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [ITEM_W-1:0]       popped_ff;
   logic [ITEM_W-1:0]       popped_in;
   logic                    found_ff;
   logic                    found_in;
   status_type              status_ff;
   status_type              status_in;

   logic             accept;
   logic             empty;
   logic             full;
   logic [WIDTH-1:0] key;
   cell_ctl_type     ctl;
   logic             any_hit;

   // Chains that run through the cell row.
   logic [WIDTH-1:0] cell_data [DEPTH];
   logic [WIDTH-1:0] upper     [DEPTH];
   logic             above     [DEPTH+1];
   logic [WIDTH-1:0] newest    [DEPTH+1];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign empty          = count_ff == '0;
   assign full           = count_ff == CW'(DEPTH);
   assign key            = WIDTH'(req_chan.item_value);

   // The match flag ripples from the newest end down; the newest-word select
   // ripples the same way, so both leave the row at cell zero.
   assign above[DEPTH]  = 1'b0;
   assign newest[DEPTH] = '0;
   assign any_hit       = above[0];

   always_comb begin
      ctl = '0;
      if (accept) begin
         unique case (op_type'(req_chan.operation))
            OP_PUSH:       ctl.do_push = !full;
            OP_POP_OLDEST: ctl.do_pop_oldest = !empty;
            OP_REMOVE:     ctl.do_remove = 1'b1;
            default:       ctl = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_top
         assign upper[i] = '0;
      end else begin : g_mid
         assign upper[i] = cell_data[i+1];
      end

      bdq_cell #(
         .WIDTH (WIDTH),
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .any_hit    (any_hit),
         .count      (count_ff),
         .key        (key),
         .upper_data (upper[i]),
         .above_in   (above[i+1]),
         .newest_in  (newest[i+1]),
         .data       (cell_data[i]),
         .above_out  (above[i]),
         .newest_out (newest[i])
      );
   end

   // Result of the request being accepted this cycle.
   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      found_in  = 1'b0;
      status_in = ST_OK;
      unique case (op_type'(req_chan.operation))
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_NEWEST: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in = ITEM_W'(newest[0]);
               count_in  = count_ff - CW'(1);
            end
         end
         OP_POP_OLDEST: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in = ITEM_W'(cell_data[0]);
               count_in  = count_ff - CW'(1);
            end
         end
         OP_REMOVE: begin
            if (any_hit) begin
               found_in = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload; the count is reported after the operation.
   logic [CW-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         found_ff     <= found_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.item_count   = ITEM_COUNT_W'(rsp_count_ff);

   `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "item count exceeds depth")
   `BDQ_ASSERT_NOW(a_hit_needs_items, any_hit, count_ff != '0, "match found in empty store")
   `BDQ_ASSERT_NEXT(a_push_grows, ctl.do_push, count_ff == $past(count_ff) + CW'(1),
      "accepted push did not grow the store")
   `BDQ_ASSERT_NEXT(a_remove_shrinks, ctl.do_remove && any_hit,
      count_ff == $past(count_ff) - CW'(1), "successful remove did not shrink the store")

endmodule

`default_nettype wire

@@ hw/rtl/bdq_cell.sv @@
// One storage cell of the deque row: holds a word, matches it and shifts down.
`default_nettype none

module bdq_cell import bdq_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT,
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int INDEX = 0,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire               clock,
   input  wire cell_ctl_type ctl,
   input  wire               any_hit,
   input  wire  [CW-1:0]     count,
   input  wire  [WIDTH-1:0]  key,
   input  wire  [WIDTH-1:0]  upper_data,
   input  wire               above_in,
   input  wire  [WIDTH-1:0]  newest_in,
   output logic [WIDTH-1:0]  data,
   output logic              above_out,
   output logic [WIDTH-1:0]  newest_out
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;
   logic             occupied;
   logic             is_newest;

   assign occupied   = CW'(INDEX) < count;
   assign is_newest  = CW'(INDEX + 1) == count;
   assign above_out  = above_in | (occupied && (data_ff == key));
   assign newest_out = newest_in | (is_newest ? data_ff : '0);
   assign data       = data_ff;

   // A remove shifts every cell from the newest match upward: the match is at or
   // below this cell exactly when a match exists and none sits above it.
   always_comb begin
      data_in = data_ff;
      if (ctl.do_push && (count == CW'(INDEX))) begin
         data_in = key;
      end else if (ctl.do_pop_oldest) begin
         data_in = upper_data;
      end else if (ctl.do_remove && any_hit && !above_in) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ tb/bounded_deque_with_remove_tb.sv @@
// Self-checking testbench for the bounded deque with push, both pops and remove-by-value.
module bounded_deque_with_remove_tb import bdq_pkg::*;;

   // The store depth matches the default build of the block under test.
   localparam int STORE_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 900;
   localparam int PHASE_COUNT   = 9;
   // One response per request and a single response register, so a short
   // settling at the end is plenty.
   localparam int SETTLE_CYCLES = 8;
   // The limit sits well above the slowest correct run, even when every item
   // meets the longest sender gap and the longest receiver stall.
   localparam int CYCLE_LIMIT   = 400000;

   // One response item of the deque, as the scoreboard holds it.
   typedef struct packed {
      logic [ITEM_W-1:0]       popped_value;
      logic                    found;
      status_type              status;
      logic [ITEM_COUNT_W-1:0] item_count;
   } deque_result_type;

   // One line of the directed stimulus table. When has_typed is set, the
   // expected response is written in the table and replaces the prediction.
   typedef struct {
      op_type            op;
      logic [ITEM_W-1:0] word;
      bit                has_typed;
      deque_result_type  typed;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdq_req_if req_chan ();
   bdq_rsp_if rsp_chan ();

   bounded_deque_with_remove uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // Predicted contents of the deque: index 0 is the oldest word and the last
   // index is the newest one, so the queue size is the item count.
   logic [ITEM_W-1:0] deque_words[$];
   // Responses that are owed by the block, oldest first.
   deque_result_type  pending_results[$];
   stimulus_row_type  directed_rows[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int stall_left   = 0;
   bit send_idle    = 1'b0;
   bit recv_idle    = 1'b0;

   // Advance the predicted deque by one request and return the response it
   // must produce. Removal searches from the newest end and takes only the
   // first match, so duplicates further down survive.
   function automatic deque_result_type apply_request(op_type op, logic [ITEM_W-1:0] word);
      deque_result_type res;
      res = '{popped_value: '0, found: 1'b0, status: ST_OK, item_count: '0};
      case (op)
         OP_PUSH: begin
            if (deque_words.size() >= STORE_DEPTH)
               res.status = ST_FULL;
            else
               deque_words.push_back(word);
         end
         OP_POP_NEWEST: begin
            if (deque_words.size() == 0)
               res.status = ST_EMPTY;
            else
               res.popped_value = deque_words.pop_back();
         end
         OP_POP_OLDEST: begin
            if (deque_words.size() == 0)
               res.status = ST_EMPTY;
            else
               res.popped_value = deque_words.pop_front();
         end
         default: begin
            for (int i = deque_words.size() - 1; i >= 0; i--) begin
               if (deque_words[i] == word) begin
                  deque_words.delete(i);
                  res.found = 1'b1;
                  break;
               end
            end
         end
      endcase
      res.item_count = ITEM_COUNT_W'(deque_words.size());
      return res;
   endfunction

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int idle_length();
      if ($urandom_range(0, 9) < 9)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_known(op_type op, logic [ITEM_W-1:0] word,
                                     logic [ITEM_W-1:0] popped, logic found,
                                     status_type status, int count);
      directed_rows.push_back('{op, word, 1'b1, '{popped, found, status, count[4:0]}});
   endfunction

   function automatic void add_open(op_type op, logic [ITEM_W-1:0] word);
      directed_rows.push_back('{op, word, 1'b0, '0});
   endfunction

   // Present one request item and hold it until the block takes it. The valid
   // line is left high after acceptance so that back-to-back items keep it up;
   // it only drops when a gap is wanted or the sender goes quiet.
   task automatic send_item(op_type op, logic [ITEM_W-1:0] word,
                            bit has_typed, deque_result_type typed);
      int gap;
      deque_result_type predicted;
      gap = (send_idle && $urandom_range(0, 99) < 30) ? idle_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.item_value <= word;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      // Accepted at this edge: the prediction always runs so the model state
      // keeps pace, even where the table already spells out the answer.
      predicted = apply_request(op, word);
      pending_results.push_back(has_typed ? typed : predicted);
   endtask

   // Stop sending and wait until every owed response has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver side: either always ready, or ready with random stalls that
   // are usually short and now and then long.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (recv_idle && $urandom_range(0, 99) < 20) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= idle_length() - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Response checker: every accepted response item is compared field by
   // field with the oldest owed response.
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: popped %h found %b status %0d count %0d",
                     $time, rsp_chan.popped_value, rsp_chan.found, rsp_chan.status,
                     rsp_chan.item_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.popped_value !== want.popped_value) begin
               $display("%0t: popped_value expected %h actual %h",
                        $time, want.popped_value, rsp_chan.popped_value);
               error_count++;
            end
            if (rsp_chan.found !== want.found) begin
               $display("%0t: found expected %b actual %b", $time, want.found, rsp_chan.found);
               error_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.item_count !== want.item_count) begin
               $display("%0t: item_count expected %0d actual %0d",
                        $time, want.item_count, rsp_chan.item_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [ITEM_W-1:0] fill_words[16];
      int push_pct;
      int pick;
      op_type op;
      logic [ITEM_W-1:0] word;

      req_chan.valid      = 1'b0;
      req_chan.operation  = OP_PUSH;
      req_chan.item_value = '0;
      rsp_chan.ready      = 1'b0;

      // Sixteen words for the fill: the all-zero and all-one words, single
      // bits at both ends, and one word pushed twice so a later removal has
      // to choose the newer copy.
      fill_words = '{32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hA5A5_A5A5,
                     32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h0000_0000,
                     32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321,
                     32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'h3333_3333};

      // Directed table. Both pops and a removal on the empty store come first,
      // then a short push/pop round trip, a fill to the brim, a push that
      // overflows, removals with and without a match after the fill, then both pops.
      add_known(OP_POP_NEWEST, 32'h0, 32'h0, 1'b0, ST_EMPTY, 0);
      add_known(OP_POP_OLDEST, 32'h0, 32'h0, 1'b0, ST_EMPTY, 0);
      add_known(OP_REMOVE,     32'h0, 32'h0, 1'b0, ST_OK,    0);
      add_known(OP_PUSH,       32'h0, 32'h0, 1'b0, ST_OK,    1);
      add_known(OP_PUSH,       32'hFFFF_FFFF, 32'h0, 1'b0, ST_OK, 2);
      add_known(OP_POP_NEWEST, 32'h0, 32'hFFFF_FFFF, 1'b0, ST_OK, 1);
      add_known(OP_POP_OLDEST, 32'h0, 32'h0, 1'b0, ST_OK, 0);
      foreach (fill_words[i])
         add_known(OP_PUSH, fill_words[i], 32'h0, 1'b0, ST_OK, i + 1);
      add_known(OP_PUSH,   32'hC3C3_C3C3, 32'h0, 1'b0, ST_FULL, STORE_DEPTH);
      add_open(OP_REMOVE,  32'hA5A5_A5A5);
      add_known(OP_REMOVE, 32'h1357_9BDF, 32'h0, 1'b0, ST_OK, STORE_DEPTH - 1);
      add_open(OP_POP_OLDEST, 32'h0);
      add_open(OP_POP_NEWEST, 32'hFFFF_FFFF);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs with idling on both sides.
      send_idle = 1'b1;
      recv_idle = 1'b1;
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].word,
                   directed_rows[i].has_typed, directed_rows[i].typed);
      drain_results();

      // Random part in phases. Each phase leans toward filling, draining or
      // balance so the store spends time near empty, near full and between,
      // and the idling on the two sides varies from phase to phase.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 5)
            0:       push_pct = 85;
            1:       push_pct = 50;
            2:       push_pct = 15;
            3:       push_pct = 65;
            default: push_pct = 35;
         endcase
         send_idle = (phase % 3) != 0;
         recv_idle = (phase % 4) != 0;
         for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
               op = OP_PUSH;
            else begin
               case ($urandom_range(0, 2))
                  0:       op = OP_POP_NEWEST;
                  1:       op = OP_POP_OLDEST;
                  default: op = OP_REMOVE;
               endcase
            end
            // Words come from a small pool often enough to produce duplicates,
            // otherwise they are fully random so every bit toggles.
            if ($urandom_range(0, 99) < 35) begin
               case ($urandom_range(0, 4))
                  0:       word = 32'h0;
                  1:       word = 32'hFFFF_FFFF;
                  2:       word = 32'h8000_0000;
                  default: word = $urandom_range(0, 7);
               endcase
            end else begin
               word = $urandom;
            end
            // Most removals target a word that is stored, so hits land at
            // every position; the rest search for whatever was drawn.
            if (op == OP_REMOVE && deque_words.size() != 0 && $urandom_range(0, 99) < 65)
               word = deque_words[$urandom_range(0, deque_words.size() - 1)];
            send_item(op, word, 1'b0, '0);
         end
         // The sender holds off here until the block has answered everything.
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_deque_with_remove.sv
tb/bounded_deque_with_remove_tb.sv
